/* src/swrpm_pkg.sv */
`timescale 1ns / 1ps
package swrpm_pkg;

    localparam int DEF_MAX_WINDOW  = 1024;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam int CFG_W        = 11;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 11'd882;

    localparam int ENERGY_W     = 57;
    localparam int ENERGY_OUT_W = 56;
    localparam int FIELD_W      = 24;

    localparam logic [ENERGY_W-1:0] ENERGY_LIMIT = '1;

    // Restoring divider takes one quotient bit per step
    localparam int DIV_STEPS  = ENERGY_W;
    // Square root retires one root bit (two radicand bits) per step
    localparam int ROOT_W     = 29;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ADD,
        ST_SUB,
        ST_BEST,
        ST_DIV_LOAD,
        ST_DIV,
        ST_SQRT_LOAD,
        ST_SQRT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic square;
        logic add;
        logic sub;
        logic best;
        logic div_load;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic end_of_note;
        logic out_free;
    } dp_status_t;

endpackage

/* src/swrpm_ctrl.sv */
`timescale 1ns / 1ps
module swrpm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  swrpm_pkg::dp_status_t  status,
    output swrpm_pkg::ctrl_cmd_t   cmd
);
    import swrpm_pkg::*;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SQUARE;
            end
            ST_SQUARE: state_next = ST_ADD;
            ST_ADD:    state_next = ST_SUB;
            ST_SUB:    state_next = ST_BEST;
            ST_BEST: begin
                state_next = status.end_of_note ? ST_DIV_LOAD : ST_IDLE;
            end
            ST_DIV_LOAD: begin
                state_next = ST_DIV;
                step_next  = '0;
            end
            ST_DIV: begin
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_SQRT_LOAD;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SQRT_LOAD: begin
                state_next = ST_SQRT;
                step_next  = '0;
            end
            ST_SQRT: begin
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_EMIT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                // hold until the output register can take the result
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = aresetn;
                cmd.accept = s_valid && aresetn;
            end
            ST_SQUARE:    cmd.square    = 1'b1;
            ST_ADD:       cmd.add       = 1'b1;
            ST_SUB:       cmd.sub       = 1'b1;
            ST_BEST:      cmd.best      = 1'b1;
            ST_DIV_LOAD:  cmd.div_load  = 1'b1;
            ST_DIV:       cmd.div_step  = 1'b1;
            ST_SQRT_LOAD: cmd.sqrt_load = 1'b1;
            ST_SQRT:      cmd.sqrt_step = 1'b1;
            ST_EMIT:      cmd.emit      = status.out_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* src/swrpm_datapath.sv */
`timescale 1ns / 1ps
module swrpm_datapath #(
    parameter int MAX_WINDOW  = swrpm_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = swrpm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swrpm_pkg::CFG_W-1:0]         cfg_window_length,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample_value,
    input  logic                                s_end_of_note,
    input  swrpm_pkg::ctrl_cmd_t                cmd,
    output swrpm_pkg::dp_status_t               status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [swrpm_pkg::FIELD_W-1:0]       m_peak_magnitude,
    output logic [swrpm_pkg::ENERGY_OUT_W-1:0]  m_max_window_energy,
    output logic [swrpm_pkg::FIELD_W-1:0]       m_impact_rms,
    output logic                                m_result_last
);
    import swrpm_pkg::*;

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 2);
    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int SUM_W = ((SQ_W > ENERGY_W) ? SQ_W : ENERGY_W) + 1;
    localparam int SH_W  = ROOT_W + 3;

    logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

    logic [CFG_W-1:0]        wlen_reg;
    logic [SAMPLE_BITS-1:0]  mag_reg, old_reg, peak_reg;
    logic                    full_reg, eon_reg;
    logic [SQ_W-1:0]         sq_reg, osq_reg;
    logic [ENERGY_W-1:0]     running_reg, best_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [PTR_W-1:0]        wp_reg;
    logic [CNT_W-1:0]        rem_reg;
    logic [ENERGY_W-1:0]     quot_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [ROOT_W:0]         srem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic                    m_valid_reg;
    logic [FIELD_W-1:0]      peak_out_reg, rms_out_reg;
    logic [ENERGY_OUT_W-1:0] energy_out_reg;

    logic [CNT_W-1:0]        w_eff;
    logic                    full;
    logic [CNT_W:0]          wp_ext, w_ext, rd_wide;
    logic [PTR_W-1:0]        rd_addr, wp_next;
    logic [SAMPLE_BITS-1:0]  sample_bits, sample_mag;
    logic [SQ_W-1:0]         sq_next, osq_next;
    logic [SUM_W-1:0]        add_sum, run_ext, osq_ext;
    logic [CNT_W:0]          div_shift, div_diff;
    logic                    div_ge;
    logic [SH_W-1:0]         sq_shift, sq_trial, sq_diff;
    logic                    sq_ge;

    // Window of zero acts as one, oversized window acts as the store depth
    always_comb begin
        if (wlen_reg == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(wlen_reg) > MAX_WINDOW) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(wlen_reg);
        end
    end

    assign full   = count_reg >= w_eff;
    assign wp_ext = (CNT_W + 1)'(wp_reg);
    assign w_ext  = (CNT_W + 1)'(w_eff);

    always_comb begin
        if (wp_ext >= w_ext) begin
            rd_wide = wp_ext - w_ext;
        end else begin
            rd_wide = wp_ext + (CNT_W + 1)'(MAX_WINDOW) - w_ext;
        end
    end
    assign rd_addr = rd_wide[PTR_W-1:0];
    assign wp_next = (32'(wp_reg) == MAX_WINDOW - 1) ? '0 : wp_reg + 1'b1;

    assign sample_bits = s_sample_value;
    assign sample_mag  = sample_bits[SAMPLE_BITS-1] ? (~sample_bits + 1'b1) : sample_bits;

    assign sq_next  = mag_reg * mag_reg;
    assign osq_next = full_reg ? (old_reg * old_reg) : '0;

    assign run_ext = SUM_W'(running_reg);
    assign osq_ext = SUM_W'(osq_reg);
    assign add_sum = run_ext + SUM_W'(sq_reg);

    assign div_shift = {rem_reg, quot_reg[ENERGY_W-1]};
    assign div_ge    = div_shift >= w_ext;
    assign div_diff  = div_shift - w_ext;

    assign sq_shift = {srem_reg, rad_reg[RAD_W-1 -: 2]};
    assign sq_trial = SH_W'({root_reg, 2'b01});
    assign sq_ge    = sq_shift >= sq_trial;
    assign sq_diff  = sq_shift - sq_trial;

    // Window store: read the leaving sample before the new one lands
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mem[wp_reg] <= sample_mag;
            old_reg     <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mag_reg  <= sample_mag;
            full_reg <= full;
            eon_reg  <= s_end_of_note;
        end
        if (cmd.square) begin
            sq_reg  <= sq_next;
            osq_reg <= osq_next;
        end
        if (cmd.div_load) begin
            rem_reg  <= '0;
            quot_reg <= best_reg;
        end else if (cmd.div_step) begin
            rem_reg  <= div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
            quot_reg <= {quot_reg[ENERGY_W-2:0], div_ge};
        end
        if (cmd.sqrt_load) begin
            rad_reg  <= RAD_W'(quot_reg);
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            srem_reg <= sq_ge ? sq_diff[ROOT_W:0] : sq_shift[ROOT_W:0];
            root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
            rad_reg  <= rad_reg << 2;
        end
        if (cmd.emit) begin
            peak_out_reg   <= FIELD_W'(peak_reg);
            energy_out_reg <= best_reg[ENERGY_W-1] ? '1 : best_reg[ENERGY_OUT_W-1:0];
            rms_out_reg    <= FIELD_W'(root_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg    <= WINDOW_RESET;
            running_reg <= '0;
            best_reg    <= '0;
            peak_reg    <= '0;
            count_reg   <= '0;
            wp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) wlen_reg <= cfg_window_length;

            if (cmd.accept) begin
                wp_reg <= wp_next;
                if (32'(count_reg) < MAX_WINDOW + 1) count_reg <= count_reg + 1'b1;
            end
            if (cmd.square && (mag_reg > peak_reg)) peak_reg <= mag_reg;
            if (cmd.add) begin
                // saturate the running sum
                running_reg <= (add_sum > SUM_W'(ENERGY_LIMIT)) ? ENERGY_LIMIT
                                                                 : add_sum[ENERGY_W-1:0];
            end
            if (cmd.sub) begin
                // drop the leaving sample, clamp at zero
                running_reg <= (run_ext >= osq_ext) ? running_reg - ENERGY_W'(osq_reg) : '0;
            end
            if (cmd.best && full_reg && (running_reg > best_reg)) best_reg <= running_reg;

            if (cmd.emit) begin
                running_reg <= '0;
                best_reg    <= '0;
                peak_reg    <= '0;
                count_reg   <= '0;
                wp_reg      <= '0;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready           = aresetn;
    assign status.end_of_note  = eon_reg;
    assign status.out_free     = !m_valid_reg || m_ready;
    assign m_valid             = m_valid_reg;
    assign m_peak_magnitude    = peak_out_reg;
    assign m_max_window_energy = energy_out_reg;
    assign m_impact_rms        = rms_out_reg;
    assign m_result_last       = 1'b1;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= MAX_WINDOW + 1)
        else $error("sample count past saturation");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(wp_reg) < MAX_WINDOW)
        else $error("write pointer out of range");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result overwrites a pending transaction");

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (running_reg == '0 && count_reg == '0 && m_valid_reg))
        else $error("note state not cleared after result");

endmodule

/* src/sliding_window_rms_peak_meter_core.sv */
`timescale 1ns / 1ps
// Sliding-window loudness meter, one note at a time.
// Input channel (s_): one signed sample per transaction plus an end-of-note
// flag. Result channel (m_): one transaction per note, carrying the peak
// magnitude, the largest window energy (saturated to 56 bits) and the floor
// root of that energy over the window length.
// Configuration channel (cfg_): window length, ready whenever out of reset;
// write it only while the block is idle. Reset value is 882 samples.
// Each sample runs accept, square, add, subtract and compare, set by the
// multiply and the two energy updates, before the next one is accepted.
// A flagged sample then runs a 57-step restoring divide and a 29-step root,
// one bit per cycle, before the result is registered for output.
// The output register holds the result while the receiver stalls; new
// samples are still accepted, and only the next note's result waits for it.
// Reset (aresetn low, synchronous) clears the note state, the window length
// and the result channel; the window store needs no clearing pass.
module sliding_window_rms_peak_meter_core #(
    parameter int MAX_WINDOW  = swrpm_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = swrpm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swrpm_pkg::CFG_W-1:0]         cfg_window_length,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample_value,
    input  logic                                s_end_of_note,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [swrpm_pkg::FIELD_W-1:0]       m_peak_magnitude,
    output logic [swrpm_pkg::ENERGY_OUT_W-1:0]  m_max_window_energy,
    output logic [swrpm_pkg::FIELD_W-1:0]       m_impact_rms,
    output logic                                m_result_last
);
    import swrpm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    swrpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    swrpm_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_window_length   (cfg_window_length),
        .s_sample_value      (s_sample_value),
        .s_end_of_note       (s_end_of_note),
        .cmd                 (cmd),
        .status              (status),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_peak_magnitude    (m_peak_magnitude),
        .m_max_window_energy (m_max_window_energy),
        .m_impact_rms        (m_impact_rms),
        .m_result_last       (m_result_last)
    );

endmodule

/* test/tb_sliding_window_rms_peak_meter_core.sv */
`timescale 1ns / 1ps
module tb_sliding_window_rms_peak_meter_core;

    import swrpm_pkg::*;

    localparam int SAMPLE_W         = DEF_SAMPLE_BITS;
    localparam int HISTORY          = DEF_MAX_WINDOW;
    localparam int IDLE_PCT         = 21;
    localparam int HOLD_CYCLES      = 400;
    localparam int SETTLE_CYCLES    = 150;
    localparam int QUIET_LIMIT      = 4000;
    localparam int MAX_REPORTS      = 10;
    localparam int PHASES           = 8;
    localparam int RANDOM_PER_PHASE = 70;

    typedef struct packed {
        logic [FIELD_W-1:0]      peak;
        logic [ENERGY_OUT_W-1:0] energy;
        logic [FIELD_W-1:0]      rms;
        logic                    last;
    } note_reading_t;

    class note_loudness_tracker;
        logic [CFG_W-1:0]    window_cfg;
        logic [SAMPLE_W-1:0] history [HISTORY];
        logic [ENERGY_W-1:0] running_energy;
        logic [ENERGY_W-1:0] best_energy;
        logic [FIELD_W-1:0]  peak;
        int unsigned         count;
        logic [9:0]          wr_ptr;
        note_reading_t       pending_readings [$];
        int                  mismatches;

        function new();
            window_cfg = WINDOW_RESET;
            foreach (history[i]) history[i] = '0;
            mismatches = 0;
            start_note();
        endfunction

        function void start_note();
            running_energy = '0;
            best_energy    = '0;
            peak           = '0;
            count          = 0;
            wr_ptr         = '0;
        endfunction

        function void set_window(logic [CFG_W-1:0] value);
            window_cfg = value;
        endfunction

        // zero behaves as one, anything past the store depth as the full store
        function int unsigned span();
            if (window_cfg == 0) return 1;
            if (window_cfg > HISTORY) return HISTORY;
            return window_cfg;
        endfunction

        function logic [63:0] floor_root(logic [63:0] x);
            logic [63:0] root;
            logic [63:0] trial;
            root = '0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= x) root = trial;
            end
            return root;
        endfunction

        function void absorb_sample(logic [SAMPLE_W-1:0] raw, logic end_flag);
            int unsigned         w;
            logic [SAMPLE_W-1:0] mag;
            logic [ENERGY_W-1:0] sq;
            logic [ENERGY_W-1:0] old_sq;
            logic [9:0]          rd_ptr;
            logic [63:0]         mean_sq;
            note_reading_t       r;
            bit                  window_full;
            w           = span();
            mag         = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
            sq          = ENERGY_W'(mag) * ENERGY_W'(mag);
            window_full = (count >= w);
            if (mag > peak) peak = mag;
            if (running_energy > ENERGY_LIMIT - sq)
                running_energy = ENERGY_LIMIT;
            else
                running_energy = running_energy + sq;
            if (window_full) begin
                // drop the sample that leaves the window, clamp at zero
                rd_ptr = 10'(wr_ptr + HISTORY - w);
                old_sq = ENERGY_W'(history[rd_ptr]) * ENERGY_W'(history[rd_ptr]);
                running_energy = (running_energy >= old_sq) ? running_energy - old_sq : '0;
                if (running_energy > best_energy) best_energy = running_energy;
            end
            history[wr_ptr] = mag;
            wr_ptr = wr_ptr + 10'd1;
            if (count < HISTORY + 1) count++;
            if (end_flag) begin
                r.peak   = peak;
                r.energy = best_energy[ENERGY_W-1] ? '1 : best_energy[ENERGY_OUT_W-1:0];
                mean_sq  = 64'(best_energy) / 64'(w);
                r.rms    = FIELD_W'(floor_root(mean_sq));
                r.last   = 1'b1;
                pending_readings.push_back(r);
                start_note();
            end
        endfunction

        function void compare_reading(note_reading_t got);
            note_reading_t want;
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected reading: peak %0d energy %0d rms %0d last %0b",
                             got.peak, got.energy, got.rms, got.last);
                return;
            end
            want = pending_readings.pop_front();
            if (got.peak !== want.peak || got.energy !== want.energy ||
                got.rms !== want.rms || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("reading mismatch: peak %0d/%0d energy %0d/%0d rms %0d/%0d last %0b/%0b",
                             want.peak, got.peak, want.energy, got.energy,
                             want.rms, got.rms, want.last, got.last);
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn           = 1'b0;
    logic                    cfg_valid         = 1'b0;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_window_length = '0;
    logic                    s_valid           = 1'b0;
    logic                    s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_value = '0;
    logic                    s_end_of_note     = 1'b0;
    logic                    m_valid;
    logic                    m_ready           = 1'b0;
    logic [FIELD_W-1:0]      m_peak_magnitude;
    logic [ENERGY_OUT_W-1:0] m_max_window_energy;
    logic [FIELD_W-1:0]      m_impact_rms;
    logic                    m_result_last;

    logic no_idle      = 1'b0;
    logic hold_request = 1'b0;
    int   quiet_cycles = 0;
    int   phase_window  [PHASES] = '{1, 4, 2047, 16, 2, 1024, 9, 3};
    int   phase_max_len [PHASES] = '{6, 14, 12, 40, 8, 10, 24, 10};

    note_loudness_tracker tracker;

    sliding_window_rms_peak_meter_core dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_window_length   (cfg_window_length),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_sample_value      (s_sample_value),
        .s_end_of_note       (s_end_of_note),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_peak_magnitude    (m_peak_magnitude),
        .m_max_window_energy (m_max_window_energy),
        .m_impact_rms        (m_impact_rms),
        .m_result_last       (m_result_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.compare_reading({m_peak_magnitude, m_max_window_energy,
                                     m_impact_rms, m_result_last});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_sliding_window_rms_peak_meter_core: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_sink
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                // hold off long enough that the block backs up into its input
                hold_request <= 1'b0;
                m_ready      <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
                @(posedge aclk);
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return '0;
            3, 4:    return SAMPLE_W'(int'($urandom_range(0, 128)) - 64);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic [SAMPLE_W-1:0] value, input logic last);
        int gap;
        gap = (!no_idle && $urandom_range(0, 99) < IDLE_PCT) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_value <= value;
        s_end_of_note  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.absorb_sample(value, last);
    endtask

    // wait out every pending reading plus the block's tail latency
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.pending_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] value);
        settle();
        cfg_valid         <= 1'b1;
        cfg_window_length <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.set_window(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_notes(input int budget, input int max_len);
        int sent;
        int len;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                              : $urandom_range(1, max_len);
            for (int k = 0; k < len; k++)
                push_sample(random_sample(), k == len - 1);
            sent += len;
        end
    endtask

    initial begin : stimulus
        tracker = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default window: notes end before any window is compared
        push_sample(24'h800000, 1'b1);
        push_sample(24'h7FFFFF, 1'b0);
        push_sample(24'h000000, 1'b0);
        push_sample(24'hFFFFFE, 1'b0);
        push_sample(24'h000001, 1'b1);

        // a zero window behaves as one sample
        write_window(11'd0);
        push_sample(24'h800000, 1'b0);
        push_sample(24'h7FFFFF, 1'b0);
        push_sample(24'hFFFFFF, 1'b1);

        // grow the window mid-note so the stale sum clamps at zero
        push_sample(24'h800000, 1'b0);
        push_sample(24'h000000, 1'b0);
        push_sample(24'h000000, 1'b0);
        write_window(11'd3);
        push_sample(24'h000000, 1'b0);
        push_sample(24'h000005, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            write_window(CFG_W'(phase_window[p]));
            case (p)
                3: no_idle <= 1'b1;
                4: hold_request <= 1'b1;
                default: ;
            endcase
            run_notes(RANDOM_PER_PHASE, phase_max_len[p]);
            no_idle <= 1'b0;
        end

        settle();
        if (tracker.mismatches == 0 && tracker.pending_readings.size() == 0)
            $display("tb_sliding_window_rms_peak_meter_core: PASS");
        else
            $display("tb_sliding_window_rms_peak_meter_core: FAIL");
        $finish;
    end

endmodule

/* sim.f */
src/swrpm_pkg.sv
src/swrpm_ctrl.sv
src/swrpm_datapath.sv
src/sliding_window_rms_peak_meter_core.sv
test/tb_sliding_window_rms_peak_meter_core.sv
